// ===== design/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared constants, codes and control types of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

   localparam int MAX_BLOCKS = 32;
   localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int ADDR_W     = 32;
   localparam int SIZE_W     = 16;
   localparam int CNT_W      = 6;
   localparam int EFF_W      = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
   localparam int DIVD_W     = IDX_W + SIZE_W;
   localparam int STEP_W     = $clog2(IDX_W + 1);
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 2'd2;

   localparam logic [SIZE_W-1:0] BLOCK_SIZE_RESET  = 16'd4;
   localparam logic [CNT_W-1:0]  BLOCK_COUNT_RESET = 6'd32;

   typedef enum logic [0:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_ALLOCATED = 2'd0,
      ST_FULL      = 2'd1,
      ST_FREED     = 2'd2,
      ST_REJECTED  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DIVIDE,
      S_RESOLVE,
      S_ENCODE,
      S_MULT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       load;
      logic       div_load;
      logic       div_step;
      logic       clear_mark;
      logic       scan;
      logic       mark_used;
      logic       mult;
      logic       out_load;
      status_type out_status;
   } cmd_type;

   typedef struct packed {
      logic op_free;
      logic free_bad;
      logic n_zero;
      logic free_ok;
      logic found;
   } stat_type;

endpackage

// ===== design/fbpa_channels.sv =====
// ----------------------------------------------------------------------------
// fbpa channels
// Valid/ready request and response channels of the block pool allocator.
// ----------------------------------------------------------------------------
interface fbpa_req_if;
   import fbpa_pkg::*;

   logic              valid;
   logic              ready;
   logic              op;
   logic [ADDR_W-1:0] free_address;

   modport source (output valid, output op, output free_address, input ready);
   modport sink   (input valid, input op, input free_address, output ready);
endinterface

interface fbpa_rsp_if;
   import fbpa_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [ADDR_W-1:0] block_address;

   modport source (output valid, output status, output block_address, input ready);
   modport sink   (input valid, input status, input block_address, output ready);
endinterface

// ===== design/fbpa_controller.sv =====
// ----------------------------------------------------------------------------
// fbpa_controller
// Sequencer of the allocator: steps one request through check, divide,
// search, address and response.
// ----------------------------------------------------------------------------
module fbpa_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output fbpa_pkg::cmd_type  cmd,
   input  fbpa_pkg::stat_type stat
);
   import fbpa_pkg::*;

   state_type           state_ff, state_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   status_type          status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         status_ff    <= ST_ALLOCATED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      status_in      = status_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.out_status = status_ff;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.op_free && stat.free_bad) begin
               status_in = ST_REJECTED;
               state_in  = S_DONE;
            end else if (!stat.op_free && stat.n_zero) begin
               status_in = ST_FULL;
               state_in  = S_DONE;
            end else begin
               cmd.div_load = 1'b1;
               cnt_in       = STEP_W'(IDX_W - 1);
               state_in     = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_RESOLVE;
            end else begin
               cnt_in = cnt_ff - STEP_W'(1);
            end
         end
         S_RESOLVE: begin
            if (stat.op_free) begin
               cmd.clear_mark = stat.free_ok;
               status_in      = stat.free_ok ? ST_FREED : ST_REJECTED;
               state_in       = S_DONE;
            end else begin
               cmd.scan = 1'b1;
               state_in = S_ENCODE;
            end
         end
         S_ENCODE: begin
            if (stat.found) begin
               cmd.mark_used = 1'b1;
               status_in     = ST_ALLOCATED;
               state_in      = S_MULT;
            end else begin
               status_in = ST_FULL;
               state_in  = S_DONE;
            end
         end
         S_MULT: begin
            cmd.mult = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || cmd.out_load;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/fbpa_datapath.sv =====
// ----------------------------------------------------------------------------
// fbpa_datapath
// Configuration registers, used marks, shared shift-subtract divider,
// circular free-block search and address multiply of the allocator.
// ----------------------------------------------------------------------------
module fbpa_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fbpa_pkg::ADDR_W-1:0]        csr_write_data,
   input  logic                               req_op,
   input  logic [fbpa_pkg::ADDR_W-1:0]        req_free_address,
   input  fbpa_pkg::cmd_type                  cmd,
   output fbpa_pkg::stat_type                 stat,
   output logic [1:0]                         rsp_status,
   output logic [fbpa_pkg::ADDR_W-1:0]        rsp_block_address
);
   import fbpa_pkg::*;

   logic [ADDR_W-1:0]     base_ff;
   logic [SIZE_W-1:0]     size_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [MAX_BLOCKS-1:0] used_ff;
   logic [IDX_W-1:0]      start_ff;
   op_type                op_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic [DIVD_W-1:0]     rem_ff, rem_in;
   logic [DIVD_W-1:0]     div_sh_ff, div_sh_in;
   logic [IDX_W-1:0]      quo_ff;
   logic [MAX_BLOCKS-1:0] free_ff, hi_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [DIVD_W-1:0]     prod_ff;
   status_type            out_status_ff;
   logic [ADDR_W-1:0]     out_addr_ff;

   logic [EFF_W-1:0]      n_eff;
   logic [ADDR_W-1:0]     offset;
   logic                  below_base;
   logic                  too_far;
   logic [SIZE_W-1:0]     divisor;
   logic                  step_ge;
   logic [MAX_BLOCKS-1:0] in_range;
   logic [MAX_BLOCKS-1:0] from_start;
   logic [MAX_BLOCKS-1:0] free_vec;
   logic [IDX_W-1:0]      idx_comb;
   logic [ADDR_W-1:0]     out_addr_in;

   function automatic logic [IDX_W-1:0] first_set(input logic [MAX_BLOCKS-1:0] v);
      logic [IDX_W-1:0] res;
      res = '0;
      for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
         if (v[i]) begin
            res = IDX_W'(i);
         end
      end
      return res;
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         size_ff  <= BLOCK_SIZE_RESET;
         count_ff <= BLOCK_COUNT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_POOL_BASE:   base_ff  <= csr_write_data;
            CSR_BLOCK_SIZE:  size_ff  <= csr_write_data[SIZE_W-1:0];
            CSR_BLOCK_COUNT: count_ff <= csr_write_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign n_eff = (EFF_W'(count_ff) > EFF_W'(MAX_BLOCKS)) ? EFF_W'(MAX_BLOCKS)
                                                           : EFF_W'(count_ff);

   // free address checks ahead of the divide
   assign offset     = addr_ff - base_ff;
   assign below_base = addr_ff < base_ff;
   // a quotient of MAX_BLOCKS or more can never be a valid index
   assign too_far    = (offset >> IDX_W) >= ADDR_W'(size_ff);

   assign divisor = (op_ff == OP_FREE) ? size_ff : SIZE_W'(n_eff);
   assign step_ge = rem_ff >= div_sh_ff;

   always_comb begin
      rem_in    = rem_ff;
      div_sh_in = div_sh_ff;
      if (cmd.div_load) begin
         rem_in    = (op_ff == OP_FREE) ? offset[DIVD_W-1:0] : DIVD_W'(start_ff);
         div_sh_in = DIVD_W'(divisor) << (IDX_W - 1);
      end else if (cmd.div_step) begin
         rem_in    = step_ge ? rem_ff - div_sh_ff : rem_ff;
         div_sh_in = div_sh_ff >> 1;
      end
   end

   // search masks: blocks below the count, and blocks at or after the start
   always_comb begin
      for (int i = 0; i < MAX_BLOCKS; i++) begin
         in_range[i]   = EFF_W'(i) < n_eff;
         from_start[i] = IDX_W'(i) >= rem_ff[IDX_W-1:0];
      end
      free_vec = ~used_ff & in_range;
   end

   assign idx_comb = (|hi_ff) ? first_set(hi_ff) : first_set(free_ff);

   assign out_addr_in = (cmd.out_status == ST_ALLOCATED) ? base_ff + ADDR_W'(prod_ff) : '0;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= op_type'(req_op);
         addr_ff <= req_free_address;
      end
      rem_ff    <= rem_in;
      div_sh_ff <= div_sh_in;
      if (cmd.div_load) begin
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= (quo_ff << 1) | IDX_W'(step_ge);
      end
      if (cmd.scan) begin
         free_ff <= free_vec;
         hi_ff   <= free_vec & from_start;
      end
      if (cmd.mark_used) begin
         idx_ff <= idx_comb;
      end
      if (cmd.mult) begin
         prod_ff <= {{SIZE_W{1'b0}}, idx_ff} * {{IDX_W{1'b0}}, size_ff};
      end
      if (cmd.out_load) begin
         out_status_ff <= cmd.out_status;
         out_addr_ff   <= out_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         start_ff <= '0;
      end else begin
         if (cmd.mark_used) begin
            used_ff[idx_comb] <= 1'b1;
            start_ff          <= idx_comb;
         end
         if (cmd.clear_mark) begin
            used_ff[quo_ff] <= 1'b0;
         end
      end
   end

   assign stat.op_free  = (op_ff == OP_FREE);
   assign stat.free_bad = below_base || (size_ff == '0) || too_far;
   assign stat.n_zero   = (n_eff == '0);
   assign stat.free_ok  = (rem_ff == '0) && (EFF_W'(quo_ff) < n_eff);
   assign stat.found    = |free_ff;

   assign rsp_status        = out_status_ff;
   assign rsp_block_address = out_addr_ff;

   a_mark_set: assert property (@(posedge clock) disable iff (reset)
      cmd.mark_used |=> used_ff[$past(idx_comb)])
      else $error("allocated block not marked used");

   a_mark_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_mark |=> !used_ff[$past(quo_ff)])
      else $error("freed block still marked used");

   a_start_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mark_used |=> EFF_W'(start_ff) < $past(n_eff))
      else $error("search start beyond block count");

endmodule

// ===== design/fixed_block_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Next-fit allocator over a pool of equal-sized blocks with one used mark
// per block; allocates, frees and validates block addresses.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req      in   req.valid/req.ready  op, free_address
//  rsp      out  rsp.valid/rsp.ready  status, block_address
//  csr      in   csr_write_enable     csr_index, csr_write_data
//
//  one request at a time: allocate runs check, the five-step shared divider
//  (start modulo count), search, multiply and response, with no multiply on a
//  full pool; a free runs check, divider (address over block size) and
//  response, skipping the divider on a failed base, size or range check, as
//  does a zero-block allocate. reset clears all used marks and search start.
//  a result waits in the output register while the next request is taken;
//  the next result then holds the controller, and req.ready, until rsp.ready.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fbpa_pkg::ADDR_W-1:0]    csr_write_data,
   fbpa_req_if.sink                       req,
   fbpa_rsp_if.source                     rsp
);
   import fbpa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   fbpa_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   fbpa_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_op            (req.op),
      .req_free_address  (req.free_address),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_status        (rsp.status),
      .rsp_block_address (rsp.block_address)
   );

   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.status != ST_ALLOCATED)) |-> (rsp.block_address == '0))
      else $error("nonzero address on a result without allocation");

endmodule

// ===== tb/sv/fixed_block_pool_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_tb
// Self-checking bench for the next-fit block pool allocator. A queue-fed
// driver offers allocate and free requests, a predictor tracks the used marks,
// the search start and the pool registers, and a monitor compares every
// response with the oldest prediction. The stimulus starts with directed
// requests, then runs random requests over many pool settings, with both
// sides idling at random in all but the last phase.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fbpa_pkg::*;

   localparam int QUIET_LIMIT   = 4000;
   localparam int HOLD_OFF_LEN  = 300;
   localparam int SEGMENT_ITEMS = 175;

   typedef struct {
      op_type      op;
      logic [31:0] address;
   } pool_request_type;

   typedef struct {
      status_type  status;
      logic [31:0] address;
   } pool_reply_type;

   logic clock;
   logic reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ADDR_W-1:0]    csr_write_data;

   fbpa_req_if req_ch ();
   fbpa_rsp_if rsp_ch ();

   fixed_block_pool_allocator dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req              (req_ch),
      .rsp              (rsp_ch)
   );

   // predictor state and register copies
   logic              pool_used [MAX_BLOCKS] = '{default: 1'b0};
   logic [IDX_W-1:0]  search_at = '0;
   logic [ADDR_W-1:0] cfg_base;
   logic [SIZE_W-1:0] cfg_size;
   logic [CNT_W-1:0]  cfg_count;

   pool_request_type req_backlog[$];
   pool_reply_type   owed_replies[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off_asks = 0;
   int hold_off_seen = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;
   int errors        = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int unsigned live_blocks();
      return (cfg_count > MAX_BLOCKS) ? MAX_BLOCKS : cfg_count;
   endfunction

   function automatic pool_reply_type apply_pool_request(op_type op, logic [31:0] address);
      pool_reply_type r;
      int unsigned n;
      int unsigned start;
      int unsigned idx;
      logic [31:0] offset;
      logic [31:0] slot;
      logic found;
      r.status  = ST_FULL;
      r.address = '0;
      n = live_blocks();
      found = 1'b0;
      if (op == OP_ALLOC) begin
         if (n != 0) begin
            start = search_at % n;
            for (int k = 0; k < n && !found; k++) begin
               idx = start + k;
               if (idx >= n)
                  idx -= n;
               if (!pool_used[idx[IDX_W-1:0]]) begin
                  found = 1'b1;
                  pool_used[idx[IDX_W-1:0]] = 1'b1;
                  search_at = idx[IDX_W-1:0];
                  r.status  = ST_ALLOCATED;
                  r.address = cfg_base + 32'(idx) * 32'(cfg_size);
               end
            end
         end
      end else begin
         r.status = ST_REJECTED;
         if (address >= cfg_base && cfg_size != 0) begin
            offset = address - cfg_base;
            slot   = offset / 32'(cfg_size);
            if (offset % 32'(cfg_size) == 0 && slot < n) begin
               pool_used[slot[IDX_W-1:0]] = 1'b0;
               r.status = ST_FREED;
            end
         end
      end
      return r;
   endfunction

   function automatic void queue_alloc();
      pool_request_type it;
      it.op      = OP_ALLOC;
      it.address = $urandom;
      req_backlog.push_back(it);
   endfunction

   function automatic void queue_free(logic [31:0] address);
      pool_request_type it;
      it.op      = OP_FREE;
      it.address = address;
      req_backlog.push_back(it);
   endfunction

   // mostly real block addresses, some past the count, misaligned or arbitrary
   function automatic logic [31:0] pick_free_address();
      int unsigned n;
      int unsigned sel;
      n = live_blocks();
      if (n == 0)
         n = 1;
      sel = $urandom_range(99);
      if (sel < 70)
         return cfg_base + 32'($urandom_range(n - 1)) * 32'(cfg_size);
      else if (sel < 80)
         return cfg_base + 32'($urandom_range(40, n)) * 32'(cfg_size);
      else if (sel < 90)
         return cfg_base + 32'($urandom_range(n - 1)) * 32'(cfg_size)
                + 32'($urandom_range(1, 3));
      else
         return $urandom;
   endfunction

   task automatic write_csr(logic [CSR_IDX_W-1:0] index, logic [31:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      case (index)
         CSR_POOL_BASE:   cfg_base  = data;
         CSR_BLOCK_SIZE:  cfg_size  = data[SIZE_W-1:0];
         CSR_BLOCK_COUNT: cfg_count = data[CNT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // upper bits of the narrow registers carry junk that must be dropped
   task automatic set_pool(logic [31:0] base, logic [15:0] size, logic [5:0] count);
      write_csr(CSR_POOL_BASE, base);
      write_csr(CSR_BLOCK_SIZE, {16'($urandom), size});
      write_csr(CSR_BLOCK_COUNT, {26'($urandom), count});
      @(negedge clock);
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (req_backlog.size() != 0 || req_ch.valid || owed_replies.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic run_segment(int seg);
      int alloc_pct;
      wait_idle();
      case (seg)
         0: set_pool($urandom, 16'd1, 6'd1);
         1: set_pool(32'd0, 16'hFFFF, 6'd32);
         2: set_pool(32'hFFFF_FFFF, 16'($urandom_range(1, 300)), 6'($urandom_range(1, 32)));
         3: set_pool($urandom, 16'($urandom_range(1, 64)), 6'd8);
         4: set_pool($urandom, 16'hFFFF, 6'd63);
         5: set_pool($urandom, 16'($urandom_range(0, 65535)), 6'($urandom_range(0, 63)));
         6: set_pool(32'd0, 16'd4, 6'd32);
         7: set_pool($urandom, 16'($urandom_range(1, 16)), 6'($urandom_range(33, 63)));
         default: set_pool($urandom, 16'($urandom_range(1, 8)), 6'd16);
      endcase
      alloc_pct = 50;
      for (int i = 0; i < SEGMENT_ITEMS; i++) begin
         // bursts lean toward filling or draining the pool
         if (i % 20 == 0)
            case ($urandom_range(2))
               0: alloc_pct = 20;
               1: alloc_pct = 50;
               default: alloc_pct = 85;
            endcase
         if ($urandom_range(99) < alloc_pct)
            queue_alloc();
         else
            queue_free(pick_free_address());
      end
      if (seg == 1 || seg == 5)
         hold_off_asks++;
   endtask

   // driver
   always @(posedge clock) begin : drive_requests
      pool_request_type nxt;
      if (reset) begin
         req_ch.valid        <= 1'b0;
         req_ch.op           <= OP_ALLOC;
         req_ch.free_address <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            owed_replies.push_back(apply_pool_request(op_type'(req_ch.op),
                                                      req_ch.free_address));
         if (!req_ch.valid || req_ch.ready) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = req_backlog.pop_front();
               req_ch.valid        <= 1'b1;
               req_ch.op           <= nxt.op;
               req_ch.free_address <= nxt.address;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : check_replies
      pool_reply_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (owed_replies.size() == 0) begin
               $display("%0t: response with nothing outstanding: status %0d address %h",
                        $realtime, rsp_ch.status, rsp_ch.block_address);
               errors++;
            end else begin
               want = owed_replies.pop_front();
               if (rsp_ch.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $realtime,
                           want.status, rsp_ch.status);
                  errors++;
               end
               if (rsp_ch.block_address !== want.address) begin
                  $display("%0t: block_address expected %h actual %h", $realtime,
                           want.address, rsp_ch.block_address);
                  errors++;
               end
            end
         end
         // long hold-off lets the block fill up and stall its input
         if (hold_off_asks != hold_off_seen) begin
            hold_off_seen <= hold_off_asks;
            hold_left     <= HOLD_OFF_LEN;
            rsp_ch.ready  <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_POOL_BASE;
      csr_write_data   = '0;
      cfg_base  = '0;
      cfg_size  = BLOCK_SIZE_RESET;
      cfg_count = BLOCK_COUNT_RESET;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle_pct = 21;
      recv_idle_pct = 88;

      // reset settings: allocate, free, double free, misaligned, past count
      queue_alloc();
      queue_alloc();
      queue_free(32'd4);
      queue_free(32'd4);
      queue_free(32'd6);
      queue_free(32'd128);
      queue_free(32'hFFFF_FFFF);
      queue_free(32'd0);
      // zero block size
      wait_idle();
      set_pool(32'h0000_0100, 16'd0, 6'd3);
      queue_alloc();
      queue_free(32'h0000_0100);
      queue_free(32'd0);
      // no blocks at all
      wait_idle();
      set_pool(32'h0000_0100, 16'd4, 6'd0);
      queue_alloc();
      queue_free(32'h0000_0100);
      // count above the limit, addresses wrapping past the top
      wait_idle();
      set_pool(32'hFFFF_FFF0, 16'hFFFF, 6'd63);
      queue_alloc();
      queue_alloc();
      queue_free(32'h0000_FFEF);
      queue_free(32'hFFFF_FFF0);
      // count lowered below the search start
      wait_idle();
      set_pool(32'hFFFF_FFF0, 16'hFFFF, 6'd2);
      queue_alloc();
      queue_alloc();
      queue_free(32'h0000_FFEF);

      for (int phase = 0; phase < 3; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               send_idle_pct = 21;
               recv_idle_pct = 88;
            end
            1: begin
               send_idle_pct = 88;
               recv_idle_pct = 21;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int s = 0; s < 3; s++)
            run_segment(phase * 3 + s);
      end

      wait_idle();
      repeat (20) @(negedge clock);
      if (owed_replies.size() != 0) begin
         $display("%0t: %0d responses never arrived", $realtime, owed_replies.size());
         errors++;
      end
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
